/* hw/rtl/frr_pkg.sv */
// shared widths and codes for the fraction reducer
package frr_pkg;

   localparam int WIDTH = 16;
   localparam int CNT_W = $clog2(WIDTH + 1);
   localparam int K_W   = $clog2(WIDTH);

   typedef enum logic [1:0] {
      STATUS_REDUCED  = 2'd0,
      STATUS_ZERO_DEN = 2'd1,
      STATUS_EXACT    = 2'd2
   } status_type;

endpackage

/* hw/rtl/frr_divider.sv */
// bit-serial restoring divider, one quotient bit per cycle
module frr_divider (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [frr_pkg::WIDTH-1:0] dividend,
   input  logic [frr_pkg::WIDTH-1:0] divisor,
   output logic                     done,
   output logic [frr_pkg::WIDTH-1:0] quotient,
   output logic [frr_pkg::WIDTH-1:0] remainder
);

   logic [frr_pkg::WIDTH-1:0] quo_ff;
   logic [frr_pkg::WIDTH-1:0] rem_ff;
   logic [frr_pkg::WIDTH-1:0] divisor_ff;
   logic [frr_pkg::CNT_W-1:0] cnt_ff;
   logic                      done_ff;
   logic [frr_pkg::WIDTH:0]   shifted;
   logic [frr_pkg::WIDTH:0]   diff;
   logic                      fit;

   assign shifted = {rem_ff, quo_ff[frr_pkg::WIDTH-1]};
   assign diff    = shifted - {1'b0, divisor_ff};
   assign fit     = !diff[frr_pkg::WIDTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            quo_ff     <= dividend;
            rem_ff     <= '0;
            divisor_ff <= divisor;
            cnt_ff     <= frr_pkg::CNT_W'(frr_pkg::WIDTH);
         end else if (cnt_ff != '0) begin
            rem_ff  <= fit ? diff[frr_pkg::WIDTH-1:0] : shifted[frr_pkg::WIDTH-1:0];
            quo_ff  <= {quo_ff[frr_pkg::WIDTH-2:0], fit};
            cnt_ff  <= cnt_ff - frr_pkg::CNT_W'(1);
            done_ff <= (cnt_ff == frr_pkg::CNT_W'(1));
         end
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

/* hw/rtl/fraction_reducer_unit.sv */
// fraction reducer top level: divide, binary gcd, then reduce both terms
//
// Input channel req_: numerator and denominator, taken when req_valid is high
// and req_stall is low. req_stall is high while an item is being worked on.
// Result channel rsp_: status, whole_part, reduced_num, reduced_den, taken
// when rsp_valid is high and rsp_stall is low. One result per item, in order.
// Work per item, at the 16-bit width:
//   zero denominator: no divide, the result is formed directly
//   exact integer: one serial divide
//   proper fraction: three serial divides (whole part, then remainder
//   and denominator by the gcd) plus the binary gcd, one shift or subtract
//   per cycle.
// One item is in work at a time; the next transfer is taken as soon as the
// previous result has been moved into the output register, even if that
// result is still stalled. A stalled result holds the block in its final
// step until the output register frees up.
// Reset (synchronous, active high) empties the output register and returns
// the block to waiting for an input transfer.
module fraction_reducer_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [frr_pkg::WIDTH-1:0] req_numerator,
   input  logic [frr_pkg::WIDTH-1:0] req_denominator,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [1:0]                rsp_status,
   output logic [frr_pkg::WIDTH-1:0] rsp_whole_part,
   output logic [frr_pkg::WIDTH-1:0] rsp_reduced_num,
   output logic [frr_pkg::WIDTH-1:0] rsp_reduced_den
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV_WHOLE,
      S_TWOS,
      S_GCD,
      S_DIV_NUM,
      S_DIV_DEN,
      S_DONE
   } state_type;

   state_type                 state_ff;
   frr_pkg::status_type       status_ff;
   logic [frr_pkg::WIDTH-1:0] num_ff;
   logic [frr_pkg::WIDTH-1:0] den_ff;
   logic [frr_pkg::WIDTH-1:0] rem_ff;
   logic [frr_pkg::WIDTH-1:0] whole_ff;
   logic [frr_pkg::WIDTH-1:0] rn_ff;
   logic [frr_pkg::WIDTH-1:0] rd_ff;
   logic [frr_pkg::WIDTH-1:0] a_ff;
   logic [frr_pkg::WIDTH-1:0] b_ff;
   logic [frr_pkg::WIDTH-1:0] g_ff;
   logic [frr_pkg::K_W-1:0]   k_ff;
   logic                      div_start_ff;
   logic [frr_pkg::WIDTH-1:0] div_a_ff;
   logic [frr_pkg::WIDTH-1:0] div_b_ff;
   logic                      rsp_valid_ff;
   frr_pkg::status_type       rsp_status_ff;
   logic [frr_pkg::WIDTH-1:0] rsp_whole_ff;
   logic [frr_pkg::WIDTH-1:0] rsp_rn_ff;
   logic [frr_pkg::WIDTH-1:0] rsp_rd_ff;

   logic                      div_done;
   logic [frr_pkg::WIDTH-1:0] div_quo;
   logic [frr_pkg::WIDTH-1:0] div_rem;
   logic [frr_pkg::WIDTH-1:0] gcd_val;

   frr_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start_ff),
      .dividend  (div_a_ff),
      .divisor   (div_b_ff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign gcd_val = a_ff << k_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         div_start_ff <= 1'b0;
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  num_ff <= req_numerator;
                  den_ff <= req_denominator;
                  if (req_denominator == '0) begin
                     status_ff <= frr_pkg::STATUS_ZERO_DEN;
                     whole_ff  <= '0;
                     rn_ff     <= req_numerator;
                     rd_ff     <= req_denominator;
                     state_ff  <= S_DONE;
                  end else begin
                     div_a_ff     <= req_numerator;
                     div_b_ff     <= req_denominator;
                     div_start_ff <= 1'b1;
                     state_ff     <= S_DIV_WHOLE;
                  end
               end
            end
            S_DIV_WHOLE: begin
               if (div_done) begin
                  whole_ff <= div_quo;
                  rem_ff   <= div_rem;
                  if (div_rem == '0) begin
                     status_ff <= frr_pkg::STATUS_EXACT;
                     rn_ff     <= num_ff;
                     rd_ff     <= den_ff;
                     state_ff  <= S_DONE;
                  end else begin
                     status_ff <= frr_pkg::STATUS_REDUCED;
                     a_ff      <= div_rem;
                     b_ff      <= den_ff;
                     k_ff      <= '0;
                     state_ff  <= S_TWOS;
                  end
               end
            end
            S_TWOS: begin
               // strip common factors of two
               if (!a_ff[0] && !b_ff[0]) begin
                  a_ff <= a_ff >> 1;
                  b_ff <= b_ff >> 1;
                  k_ff <= k_ff + frr_pkg::K_W'(1);
               end else begin
                  state_ff <= S_GCD;
               end
            end
            S_GCD: begin
               if (!a_ff[0]) begin
                  a_ff <= a_ff >> 1;
               end else if (!b_ff[0]) begin
                  b_ff <= b_ff >> 1;
               end else if (a_ff == b_ff) begin
                  g_ff         <= gcd_val;
                  div_a_ff     <= rem_ff;
                  div_b_ff     <= gcd_val;
                  div_start_ff <= 1'b1;
                  state_ff     <= S_DIV_NUM;
               end else if (a_ff > b_ff) begin
                  a_ff <= a_ff - b_ff;
               end else begin
                  b_ff <= b_ff - a_ff;
               end
            end
            S_DIV_NUM: begin
               if (div_done) begin
                  rn_ff        <= div_quo;
                  div_a_ff     <= den_ff;
                  div_b_ff     <= g_ff;
                  div_start_ff <= 1'b1;
                  state_ff     <= S_DIV_DEN;
               end
            end
            S_DIV_DEN: begin
               if (div_done) begin
                  rd_ff    <= div_quo;
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= status_ff;
                  rsp_whole_ff  <= whole_ff;
                  rsp_rn_ff     <= rn_ff;
                  rsp_rd_ff     <= rd_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_whole_part  = rsp_whole_ff;
   assign rsp_reduced_num = rsp_rn_ff;
   assign rsp_reduced_den = rsp_rd_ff;

endmodule
